FILE: hw/rtl/fall_detector_fsm_defines.svh
// Assertion macros shared by the fall detector RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef FALL_DETECTOR_FSM_DEFINES_SVH
`define FALL_DETECTOR_FSM_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fd_pkg.sv
// Shared types and constants of the fall detector.
// No dependencies; imported by fall_detector_fsm.
package fd_pkg;

  // Detector states, as reported in fsm_state
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_FREEFALL = 3'd1,
    ST_IMPACT   = 3'd2,
    ST_WAIT     = 3'd3,
    ST_ALARM    = 3'd4
  } fd_state_t;

  // Item kinds carried in in_tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_RESET  = 2'd2
  } fd_op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FILTER_WEIGHT   = 3'd0,
    CFG_FREEFALL_LEVEL  = 3'd1,
    CFG_IMPACT_LEVEL    = 3'd2,
    CFG_LYING_ANGLE     = 3'd3,
    CFG_FREEFALL_TO_MS  = 3'd4,
    CFG_IMPACT_SETTLE   = 3'd5,
    CFG_LIE_CONFIRM_MS  = 3'd6
  } fd_cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 88;

  // Register reset values
  localparam logic [8:0]  RST_FILTER_WEIGHT  = 9'd128;
  localparam logic [14:0] RST_FREEFALL_LEVEL = 15'd500;
  localparam logic [14:0] RST_IMPACT_LEVEL   = 15'd2000;
  localparam logic [14:0] RST_LYING_ANGLE    = 15'd7000;
  localparam logic [15:0] RST_FREEFALL_TO_MS = 16'd150;
  localparam logic [15:0] RST_IMPACT_SETTLE  = 16'd1000;
  localparam logic [15:0] RST_LIE_CONFIRM_MS = 16'd5000;

  // Fixed thresholds: one g, the near-one-g window (1 g +/- 0.3 g), 50 dps
  localparam logic [14:0]        ONE_G_MG   = 15'd1000;
  localparam logic [14:0]        NEAR_G_LO  = 15'd700;
  localparam logic [14:0]        NEAR_G_HI  = 15'd1300;
  localparam logic signed [15:0] QUIET_GYRO = 16'sd500;
  localparam logic [8:0]         FULL_WEIGHT = 9'd256;

endpackage

FILE: hw/rtl/fall_detector_fsm.sv
// Fall detector top level: input stage, smoothing filters, state machine, result register.
// Depends on fd_pkg and fall_detector_fsm_defines.svh.
//
// Usage:
//   Input channel (in_*): one beat per item. in_tuser selects the kind: sensor
//   sample, one-millisecond tick or detector reset. in_tdata carries the raw
//   acceleration, gyro rate, pitch and roll (used by samples only).
//   Result channel (out_*): exactly one beat per input beat, in order, with the
//   state, the alarm latch, the alarm pulse, the four filter values and the
//   peak tilt as they stand after that item.
//   Configuration port (cfg_*): register writes, to be issued only while no
//   item is in flight.
// Path from input beat to result beat: input register, then filters and state
//   machine into the result register.
// Throughput: one item per cycle unless the result channel stalls; the filters
//   and the state update are combinational, so an item may follow the previous one directly.
// Reset (rst_n low): state idle, filters at one g / zero, registers at their
//   defaults, both channels empty.
// Stall: when out_tready is low with a result held, the whole pipeline stops
//   and in_tready drops in the same cycle; nothing is lost or repeated.
`include "fall_detector_fsm_defines.svh"

module fall_detector_fsm
  import fd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: accel_mg[14:0], gyro_rate[30:15], pitch_angle[46:31],
  //        roll_angle[62:47], zero pad [63]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]            in_tuser,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: fsm_state[2:0], alert_flag[3], alarm_pulse[4], smooth_accel[19:5],
  //        smooth_gyro[35:20], smooth_pitch[51:36], smooth_roll[67:52],
  //        peak_tilt[82:68], zero pad [87:83]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Floor of (w*prev + (256-w)*x) / 256 on 17-bit signed values
  function automatic logic signed [16:0] fd_smooth(input logic [8:0] w,
                                                    input logic signed [16:0] prev,
                                                    input logic signed [16:0] x);
    logic signed [26:0] s;
    s = 27'($signed({1'b0, w})) * 27'(prev)
      + 27'($signed({1'b0, FULL_WEIGHT - w})) * 27'(x);
    return s[24:8];
  endfunction

  // Absolute value of a 16-bit signed value
  function automatic logic [16:0] fd_abs(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  // Configuration registers
  logic [8:0]  filter_weight_r;
  logic [14:0] freefall_level_r;
  logic [14:0] impact_level_r;
  logic [14:0] lying_angle_r;
  logic [15:0] freefall_to_ms_r;
  logic [15:0] impact_settle_ms_r;
  logic [15:0] lie_confirm_ms_r;

  // Input stage
  logic        s1_valid_r;
  fd_op_t      s1_op_r;
  logic [14:0] s1_accel_r;
  logic signed [15:0] s1_gyro_r;
  logic signed [15:0] s1_pitch_r;
  logic signed [15:0] s1_roll_r;

  // Detector state
  fd_state_t   mode_r, mode_nxt;
  logic        alarm_latch_r, alarm_latch_nxt;
  logic [14:0] accel_avg_r, accel_avg_nxt;
  logic signed [15:0] gyro_avg_r, gyro_avg_nxt;
  logic signed [15:0] pitch_avg_r, pitch_avg_nxt;
  logic signed [15:0] roll_avg_r, roll_avg_nxt;
  logic [15:0] phase_ms_r, phase_ms_nxt;
  logic        still_active_r, still_active_nxt;
  logic [15:0] still_ms_r, still_ms_nxt;

  // Result register
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic        advance;
  logic        do_item;
  logic [8:0]  w_eff;
  logic signed [16:0] accel_f, gyro_f, pitch_f, roll_f;
  logic [16:0] pitch_mag, roll_mag, tilt_max;
  logic [14:0] tilt;
  logic        pulse;
  logic [15:0] phase_inc, still_inc;

  // Pipeline moves when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign do_item   = s1_valid_r && advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_weight_r    <= RST_FILTER_WEIGHT;
      freefall_level_r   <= RST_FREEFALL_LEVEL;
      impact_level_r     <= RST_IMPACT_LEVEL;
      lying_angle_r      <= RST_LYING_ANGLE;
      freefall_to_ms_r   <= RST_FREEFALL_TO_MS;
      impact_settle_ms_r <= RST_IMPACT_SETTLE;
      lie_confirm_ms_r   <= RST_LIE_CONFIRM_MS;
    end else if (cfg_we) begin
      case (fd_cfg_idx_t'(cfg_index))
        CFG_FILTER_WEIGHT:  filter_weight_r    <= cfg_wdata[8:0];
        CFG_FREEFALL_LEVEL: freefall_level_r   <= cfg_wdata[14:0];
        CFG_IMPACT_LEVEL:   impact_level_r     <= cfg_wdata[14:0];
        CFG_LYING_ANGLE:    lying_angle_r      <= cfg_wdata[14:0];
        CFG_FREEFALL_TO_MS: freefall_to_ms_r   <= cfg_wdata;
        CFG_IMPACT_SETTLE:  impact_settle_ms_r <= cfg_wdata;
        CFG_LIE_CONFIRM_MS: lie_confirm_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      s1_op_r    <= fd_op_t'(in_tuser);
      s1_accel_r <= in_tdata[14:0];
      s1_gyro_r  <= in_tdata[30:15];
      s1_pitch_r <= in_tdata[46:31];
      s1_roll_r  <= in_tdata[62:47];
    end
  end

  // Filters: a weight above full scale holds the previous value
  assign w_eff   = (filter_weight_r > FULL_WEIGHT) ? FULL_WEIGHT : filter_weight_r;
  assign accel_f = fd_smooth(w_eff, $signed({2'b00, accel_avg_r}),
                             $signed({2'b00, s1_accel_r}));
  assign gyro_f  = fd_smooth(w_eff, {gyro_avg_r[15], gyro_avg_r}, {s1_gyro_r[15], s1_gyro_r});
  assign pitch_f = fd_smooth(w_eff, {pitch_avg_r[15], pitch_avg_r},
                             {s1_pitch_r[15], s1_pitch_r});
  assign roll_f  = fd_smooth(w_eff, {roll_avg_r[15], roll_avg_r}, {s1_roll_r[15], s1_roll_r});

  // Tilt of the filter values after this item, saturated to 15 bits
  assign pitch_mag = fd_abs(pitch_avg_nxt);
  assign roll_mag  = fd_abs(roll_avg_nxt);
  assign tilt_max  = (pitch_mag > roll_mag) ? pitch_mag : roll_mag;
  assign tilt      = (tilt_max[16] || tilt_max[15]) ? 15'h7FFF : tilt_max[14:0];

  // Saturating millisecond counters
  assign phase_inc = (phase_ms_r == 16'hFFFF) ? phase_ms_r : phase_ms_r + 16'd1;
  assign still_inc = (still_ms_r == 16'hFFFF) ? still_ms_r : still_ms_r + 16'd1;

  // Filter update: tilt must see the new pitch and roll before the decisions
  always_comb begin
    accel_avg_nxt = accel_avg_r;
    gyro_avg_nxt  = gyro_avg_r;
    pitch_avg_nxt = pitch_avg_r;
    roll_avg_nxt  = roll_avg_r;
    if (do_item) begin
      case (s1_op_r)
        OP_SAMPLE: begin
          accel_avg_nxt = accel_f[14:0];
          gyro_avg_nxt  = gyro_f[15:0];
          pitch_avg_nxt = pitch_f[15:0];
          roll_avg_nxt  = roll_f[15:0];
        end
        OP_RESET: begin
          accel_avg_nxt = ONE_G_MG;
          pitch_avg_nxt = '0;
          roll_avg_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  // State machine: next state and the alarm pulse
  always_comb begin
    mode_nxt         = mode_r;
    alarm_latch_nxt  = alarm_latch_r;
    phase_ms_nxt     = phase_ms_r;
    still_active_nxt = still_active_r;
    still_ms_nxt     = still_ms_r;
    pulse            = 1'b0;
    if (do_item) begin
      case (s1_op_r)
        OP_SAMPLE: begin
          case (mode_r)
            ST_IDLE: begin
              if (s1_accel_r < freefall_level_r) begin
                mode_nxt     = ST_FREEFALL;
                phase_ms_nxt = '0;
              end
            end
            ST_FREEFALL: begin
              if (s1_accel_r >= impact_level_r) begin
                mode_nxt     = ST_IMPACT;
                phase_ms_nxt = '0;
              end
            end
            ST_WAIT: begin
              if (tilt >= lying_angle_r) begin
                if (s1_gyro_r < QUIET_GYRO) begin
                  if (!still_active_r) begin
                    // Arm the quiet timer on the first quiet lying sample
                    still_active_nxt = 1'b1;
                    still_ms_nxt     = '0;
                  end else if (still_ms_r >= lie_confirm_ms_r &&
                               accel_avg_nxt > NEAR_G_LO && accel_avg_nxt < NEAR_G_HI) begin
                    mode_nxt         = ST_ALARM;
                    alarm_latch_nxt  = 1'b1;
                    pulse            = 1'b1;
                    still_active_nxt = 1'b0;
                    still_ms_nxt     = '0;
                  end
                end else begin
                  still_active_nxt = 1'b0;
                  still_ms_nxt     = '0;
                end
              end else begin
                still_active_nxt = 1'b0;
                still_ms_nxt     = '0;
                mode_nxt         = ST_IDLE;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (still_active_r) begin
            still_ms_nxt = still_inc;
          end
          case (mode_r)
            ST_FREEFALL: begin
              phase_ms_nxt = phase_inc;
              if (phase_inc >= freefall_to_ms_r) begin
                mode_nxt = ST_IDLE;
              end
            end
            ST_IMPACT: begin
              phase_ms_nxt = phase_inc;
              if (phase_inc >= impact_settle_ms_r) begin
                if (tilt >= lying_angle_r) begin
                  still_active_nxt = 1'b0;
                  still_ms_nxt     = '0;
                  mode_nxt         = ST_WAIT;
                end else begin
                  mode_nxt = ST_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        OP_RESET: begin
          mode_nxt         = ST_IDLE;
          alarm_latch_nxt  = 1'b0;
          phase_ms_nxt     = '0;
          still_active_nxt = 1'b0;
          still_ms_nxt     = '0;
        end
        default: ;
      endcase
    end
  end

  // Pack the result beat
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[2:0]   = mode_nxt;
    out_data_nxt[3]     = alarm_latch_nxt;
    out_data_nxt[4]     = pulse;
    out_data_nxt[19:5]  = accel_avg_nxt;
    out_data_nxt[35:20] = gyro_avg_nxt;
    out_data_nxt[51:36] = pitch_avg_nxt;
    out_data_nxt[67:52] = roll_avg_nxt;
    out_data_nxt[82:68] = tilt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= ST_IDLE;
      alarm_latch_r  <= 1'b0;
      accel_avg_r    <= ONE_G_MG;
      gyro_avg_r     <= '0;
      pitch_avg_r    <= '0;
      roll_avg_r     <= '0;
      phase_ms_r     <= '0;
      still_active_r <= 1'b0;
      still_ms_r     <= '0;
    end else begin
      mode_r         <= mode_nxt;
      alarm_latch_r  <= alarm_latch_nxt;
      accel_avg_r    <= accel_avg_nxt;
      gyro_avg_r     <= gyro_avg_nxt;
      pitch_avg_r    <= pitch_avg_nxt;
      roll_avg_r     <= roll_avg_nxt;
      phase_ms_r     <= phase_ms_nxt;
      still_active_r <= still_active_nxt;
      still_ms_r     <= still_ms_nxt;
    end
  end

  // Result register: load on each processed item, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_item) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `FD_ASSERT_SAME(a_alarm_latched, mode_r == ST_ALARM, alarm_latch_r, "alarm state without latch")
  `FD_ASSERT_SAME(a_still_in_wait, still_active_r, mode_r == ST_WAIT, "quiet timer armed outside wait")
  `FD_ASSERT_NEXT(a_item_to_result, do_item, out_valid_r, "processed item gave no result")
  `FD_ASSERT_SAME(a_pulse_alarm, out_valid_r && out_data_r[4],
                  out_data_r[2:0] == ST_ALARM && out_data_r[3], "alarm pulse outside alarm")

endmodule
